// ----- sv/nmea_sentence_framer_unit_macros.svh -----
// assertion macros for the nmea sentence framer
// no dependencies; expects clk and rst_n in the including scope
`ifndef NMEA_SENTENCE_FRAMER_UNIT_MACROS_SVH
`define NMEA_SENTENCE_FRAMER_UNIT_MACROS_SVH

// same-cycle implication, idle under reset
`define NSF_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nsf same-cycle check failed");

// next-cycle implication, idle under reset
`define NSF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nsf next-cycle check failed");

`endif

// ----- sv/nsf_pkg.sv -----
// constants, types and helpers for the nmea sentence framer
// no dependencies
`default_nettype none
package nsf_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned HEX_W       = 5;

    localparam logic [BYTE_W-1:0] SYM_DOLLAR  = 8'h24;
    localparam logic [BYTE_W-1:0] SYM_STAR    = 8'h2A;
    localparam logic [BYTE_W-1:0] LIMIT_SLACK = 8'd6;
    localparam logic [BYTE_W-1:0] LIMIT_RESET = 8'd88;
    localparam logic [BYTE_W-1:0] COUNT_MAX   = 8'd255;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_value;
        logic              sentence_start;
        logic              in_sentence;
        logic              sentence_end;
        logic              checksum_ok;
        logic              dropped;
        logic [BYTE_W-1:0] computed_xor;
    } nsf_res_t;

    // hex digit value in the low nibble, bit 4 set when not a hex digit
    function automatic logic [HEX_W-1:0] hex_value(input logic [BYTE_W-1:0] c);
        logic [HEX_W-1:0] v;
        begin
            if (c >= 8'h30 && c <= 8'h39)
            begin
                v = HEX_W'(c - 8'h30);
            end
            else if (c >= 8'h41 && c <= 8'h46)
            begin
                v = HEX_W'(c - 8'h37);
            end
            else if (c >= 8'h61 && c <= 8'h66)
            begin
                v = HEX_W'(c - 8'h57);
            end
            else
            begin
                v = 5'h10;
            end
            return v;
        end
    endfunction

endpackage
`default_nettype wire

// ----- sv/nsf_ifs.sv -----
// channel interfaces of the nmea sentence framer
// depends on nsf_pkg
`default_nettype none
interface nsf_rx_if;
    import nsf_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface nsf_res_if;
    import nsf_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] byte_value;
    logic              sentence_start;
    logic              in_sentence;
    logic              sentence_end;
    logic              checksum_ok;
    logic              dropped;
    logic [BYTE_W-1:0] computed_xor;
    modport source (output valid, output byte_value, output sentence_start,
                    output in_sentence, output sentence_end, output checksum_ok,
                    output dropped, output computed_xor, input ready);
    modport sink (input valid, input byte_value, input sentence_start,
                  input in_sentence, input sentence_end, input checksum_ok,
                  input dropped, input computed_xor, output ready);
endinterface

interface nsf_cfg_if;
    import nsf_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] length_limit;
    modport source (output valid, output length_limit, input ready);
    modport sink (input valid, input length_limit, output ready);
endinterface
`default_nettype wire

// ----- sv/nmea_sentence_framer_unit.sv -----
// nmea sentence framer: frames '$' ... '*hh' sentences from a byte stream
// depends on nsf_pkg, nsf_ifs and nmea_sentence_framer_unit_macros.svh
//
// channel | dir | payload                                     | transaction
// --------+-----+---------------------------------------------+------------------
// rx      | in  | rx_byte                                     | valid & ready
// result  | out | byte_value, flags, computed_xor             | valid & ready
// cfg     | in  | length_limit (always ready)                 | valid & ready
//
// one byte per cycle sustained while result.ready stays high; a byte enters
// the input register at its transaction and moves on to the result register
// once that register is free or being taken, and its result is taken there
// the framing state is updated as a byte moves from input to result register
// rx stays ready while the input register is empty, or the result register
// is empty or being taken
// rst_n clears state to seek start and length_limit to 88
`default_nettype none
`include "nmea_sentence_framer_unit_macros.svh"
module nmea_sentence_framer_unit (
    input  wire        clk,
    input  wire        rst_n,
    nsf_rx_if.sink     rx,
    nsf_res_if.source  result,
    nsf_cfg_if.sink    cfg
);
    import nsf_pkg::*;

    typedef enum logic [1:0] {
        ST_SEEK = 2'd0,
        ST_BODY = 2'd1,
        ST_CS1  = 2'd2,
        ST_CS2  = 2'd3
    } state_t;

    // framing state
    state_t             state_reg, state_next;
    logic [BYTE_W-1:0]  count_reg, count_next;
    logic [BYTE_W-1:0]  xor_reg, xor_next;
    logic [HEX_W-1:0]   hi_reg, hi_next;
    logic [BYTE_W-1:0]  limit_reg;

    // input register
    logic               in_valid_reg;
    logic [BYTE_W-1:0]  in_byte_reg;

    // result register
    logic               out_valid_reg;
    nsf_res_t           res_reg, res_next;

    logic               advance;
    logic               step;
    logic               take_in;
    logic [BYTE_W-1:0]  count_inc;
    logic [HEX_W-1:0]   lo_val;
    logic [BYTE_W:0]    drop_bound;

    // result register free, or emptied this cycle
    assign advance = !out_valid_reg || result.ready;
    // a byte moves into the result register and updates the state
    assign step    = advance && in_valid_reg;
    assign rx.ready = !in_valid_reg || advance;
    assign take_in  = rx.valid && rx.ready;
    assign cfg.ready = 1'b1;

    assign lo_val     = hex_value(in_byte_reg);
    assign count_inc  = (count_reg == COUNT_MAX) ? count_reg : count_reg + 8'd1;
    assign drop_bound = {1'b0, limit_reg} + {1'b0, LIMIT_SLACK};

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        xor_next   = xor_reg;
        hi_next    = hi_reg;
        res_next   = '0;
        res_next.byte_value = in_byte_reg;

        if (in_byte_reg == SYM_DOLLAR)
        begin
            // a dollar always restarts the candidate
            res_next.sentence_start = 1'b1;
            res_next.in_sentence    = 1'b1;
            state_next = ST_BODY;
            count_next = 8'd1;
            xor_next   = '0;
            hi_next    = '0;
        end
        else if (state_reg != ST_SEEK)
        begin
            res_next.in_sentence = 1'b1;
            if (state_reg == ST_CS2)
            begin
                // second checksum character closes the sentence, never dropped
                res_next.sentence_end = 1'b1;
                res_next.computed_xor = xor_reg;
                res_next.checksum_ok  = !hi_reg[HEX_W-1] && !lo_val[HEX_W-1] &&
                                        ({hi_reg[3:0], lo_val[3:0]} == xor_reg);
                state_next = ST_SEEK;
                count_next = '0;
                xor_next   = '0;
                hi_next    = '0;
            end
            else
            begin
                case (state_reg)
                    ST_BODY:
                    begin
                        if (in_byte_reg == SYM_STAR)
                        begin
                            state_next = ST_CS1;
                        end
                        else
                        begin
                            xor_next = xor_reg ^ in_byte_reg;
                        end
                    end
                    ST_CS1:
                    begin
                        hi_next    = lo_val;
                        state_next = ST_CS2;
                    end
                    default:
                    begin
                        state_next = state_reg;
                    end
                endcase
                res_next.computed_xor = xor_next;
                count_next = count_inc;
                // length overrun abandons the candidate
                if ({1'b0, count_inc} > drop_bound)
                begin
                    res_next.dropped = 1'b1;
                    state_next = ST_SEEK;
                    count_next = '0;
                    xor_next   = '0;
                    hi_next    = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SEEK;
            count_reg     <= '0;
            xor_reg       <= '0;
            hi_reg        <= '0;
            limit_reg     <= LIMIT_RESET;
            in_valid_reg  <= 1'b0;
            in_byte_reg   <= '0;
            out_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                limit_reg <= cfg.length_limit;
            end
            if (rx.ready)
            begin
                in_valid_reg <= rx.valid;
            end
            if (take_in)
            begin
                in_byte_reg <= rx.rx_byte;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (step)
            begin
                res_reg   <= res_next;
                state_reg <= state_next;
                count_reg <= count_next;
                xor_reg   <= xor_next;
                hi_reg    <= hi_next;
            end
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.byte_value     = res_reg.byte_value;
    assign result.sentence_start = res_reg.sentence_start;
    assign result.in_sentence    = res_reg.in_sentence;
    assign result.sentence_end   = res_reg.sentence_end;
    assign result.checksum_ok    = res_reg.checksum_ok;
    assign result.dropped        = res_reg.dropped;
    assign result.computed_xor   = res_reg.computed_xor;

    // a pass can only be reported on the closing character
    `NSF_ASSERT_IMPL(a_ok_at_end, out_valid_reg && res_reg.checksum_ok, res_reg.sentence_end && res_reg.in_sentence)
    // drop and end are exclusive, and both belong to a sentence
    `NSF_ASSERT_IMPL(a_drop_not_end, out_valid_reg && res_reg.dropped, res_reg.in_sentence && !res_reg.sentence_end && !res_reg.sentence_start)
    // bytes outside a sentence carry no flags and no xor
    `NSF_ASSERT_IMPL(a_outside_clean, out_valid_reg && !res_reg.in_sentence, res_reg.computed_xor == 8'd0 && !res_reg.sentence_end && !res_reg.dropped)
    // seek start always holds cleared accumulators
    `NSF_ASSERT_IMPL(a_seek_clear, state_reg == ST_SEEK, count_reg == 8'd0 && xor_reg == 8'd0 && hi_reg == 5'd0)
    // a dropped or ended sentence leaves the framer in seek start
    `NSF_ASSERT_NEXT(a_end_to_seek, step && (res_next.dropped || res_next.sentence_end), state_reg == ST_SEEK)

endmodule
`default_nettype wire

// ----- tb/nmea_sentence_framer_unit_tb.sv -----
// self-checking testbench for nmea_sentence_framer_unit: byte stream in, one result per byte
// depends on nsf_pkg, the channel interfaces in nsf_ifs and the framer rtl
// a scoreboard class tracks the framing state and checks every result transaction
module nmea_sentence_framer_unit_tb;
    import nsf_pkg::*;

    // generous bound: every byte may wait out sender gaps and receiver stalls
    localparam int CYCLE_LIMIT = 400000;

    typedef enum logic [1:0] {FRM_SEEK, FRM_BODY, FRM_CS1, FRM_CS2} frame_phase_t;

    // ------------------------------------------------------------------
    // scoreboard: own copy of the framing state and the length limit
    // ------------------------------------------------------------------
    class sentence_scoreboard;
        localparam int PRINT_CAP = 40;

        nsf_res_t          expected_results[$];
        frame_phase_t      phase;
        logic [BYTE_W-1:0] limit;
        logic [BYTE_W-1:0] count;
        logic [BYTE_W-1:0] xor_acc;
        logic [HEX_W-1:0]  first_digit;
        int                errors;

        function new();
            limit  = LIMIT_RESET;
            errors = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            phase       = FRM_SEEK;
            count       = '0;
            xor_acc     = '0;
            first_digit = '0;
        endfunction

        // value of a checksum character; bit 4 marks a non-hex character
        function logic [HEX_W-1:0] digit_of(logic [BYTE_W-1:0] c);
            logic [BYTE_W-1:0] folded;
            folded = c | 8'h20;
            if (c >= "0" && c <= "9")
            begin
                return {1'b0, c[3:0]};
            end
            if (folded >= "a" && folded <= "f")
            begin
                return HEX_W'(folded - "a" + 8'd10);
            end
            return 5'h10;
        endfunction

        // an accepted byte: step the framer and queue the result it causes
        function void note_byte(logic [BYTE_W-1:0] b);
            nsf_res_t         want;
            logic [HEX_W-1:0] second_digit;
            want            = '0;
            want.byte_value = b;
            if (b == SYM_DOLLAR)
            begin
                want.sentence_start = 1'b1;
                want.in_sentence    = 1'b1;
                clear_frame();
                phase = FRM_BODY;
                count = 8'd1;
            end
            else if (phase != FRM_SEEK)
            begin
                want.in_sentence = 1'b1;
                if (phase == FRM_CS2)
                begin
                    second_digit        = digit_of(b);
                    want.sentence_end   = 1'b1;
                    want.computed_xor   = xor_acc;
                    want.checksum_ok    = !first_digit[4] && !second_digit[4] &&
                                          ({first_digit[3:0], second_digit[3:0]} == xor_acc);
                    clear_frame();
                end
                else
                begin
                    if (phase == FRM_BODY)
                    begin
                        if (b == SYM_STAR)
                        begin
                            phase = FRM_CS1;
                        end
                        else
                        begin
                            xor_acc ^= b;
                        end
                    end
                    else
                    begin
                        first_digit = digit_of(b);
                        phase       = FRM_CS2;
                    end
                    want.computed_xor = xor_acc;
                    if (count != COUNT_MAX)
                    begin
                        count++;
                    end
                    if (int'(count) > int'(limit) + int'(LIMIT_SLACK))
                    begin
                        want.dropped = 1'b1;
                        clear_frame();
                    end
                end
            end
            expected_results.push_back(want);
        endfunction

        task report(string what, logic [BYTE_W-1:0] got, logic [BYTE_W-1:0] want);
            errors++;
            if (errors <= PRINT_CAP)
            begin
                $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
            end
        endtask

        task check_result(nsf_res_t got);
            nsf_res_t want;
            if (expected_results.size() == 0)
            begin
                report("unexpected result, byte_value", got.byte_value, '0);
                return;
            end
            want = expected_results.pop_front();
            if (got.byte_value !== want.byte_value)
                report("byte_value", got.byte_value, want.byte_value);
            if (got.sentence_start !== want.sentence_start)
                report("sentence_start", got.sentence_start, want.sentence_start);
            if (got.in_sentence !== want.in_sentence)
                report("in_sentence", got.in_sentence, want.in_sentence);
            if (got.sentence_end !== want.sentence_end)
                report("sentence_end", got.sentence_end, want.sentence_end);
            if (got.checksum_ok !== want.checksum_ok)
                report("checksum_ok", got.checksum_ok, want.checksum_ok);
            if (got.dropped !== want.dropped)
                report("dropped", got.dropped, want.dropped);
            if (got.computed_xor !== want.computed_xor)
                report("computed_xor", got.computed_xor, want.computed_xor);
        endtask
    endclass

    // ------------------------------------------------------------------
    // clock, reset, channels and the block
    // ------------------------------------------------------------------
    logic clk;
    logic rst_n;

    nsf_rx_if  rx_ch ();
    nsf_res_if res_ch ();
    nsf_cfg_if cfg_ch ();

    nmea_sentence_framer_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    sentence_scoreboard sb;
    bit                 idle_on;     // random gaps and stalls enabled
    int                 items_sent;
    int                 cycle_count;

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog: a hung handshake ends the run as a failure
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("** nmea_sentence_framer_unit: FAILED **");
        $finish;
    end

    // result side: check each result transaction, then pick the next ready
    // values are sampled before any update of this edge takes effect
    // ready is low while reset is held
    always @(posedge clk)
    begin : result_monitor
        nsf_res_t got;
        if (rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            got = '{res_ch.byte_value, res_ch.sentence_start, res_ch.in_sentence,
                    res_ch.sentence_end, res_ch.checksum_ok, res_ch.dropped,
                    res_ch.computed_xor};
            sb.check_result(got);
        end
        res_ch.ready <= rst_n && (!idle_on || $urandom_range(99) >= 9);
    end

    // ------------------------------------------------------------------
    // stimulus tasks; each one is entered just after a rising edge
    // ------------------------------------------------------------------

    // one byte transaction, with an occasional gap in front of it
    // valid stays high between back-to-back bytes
    task send_byte(input logic [BYTE_W-1:0] b);
        while (idle_on && $urandom_range(99) < 9)
        begin
            rx_ch.valid <= 1'b0;
            @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do
            @(posedge clk);
        while (rx_ch.ready !== 1'b1);
        sb.note_byte(b);
        items_sent++;
    endtask

    task send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_byte(s[i]);
        end
    endtask

    // sender holds off until every queued result has been taken
    // and then lets the two-stage pipeline empty
    task wait_for_results();
        rx_ch.valid <= 1'b0;
        while (sb.expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // register write only while the framer is idle
    task write_limit(input logic [BYTE_W-1:0] v);
        wait_for_results();
        cfg_ch.valid        <= 1'b1;
        cfg_ch.length_limit <= v;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        sb.limit = v;
    endtask

    function logic [BYTE_W-1:0] hex_char(input logic [3:0] n, input bit upper);
        if (n < 4'd10)
        begin
            return 8'("0") + 8'(n);
        end
        return (upper ? 8'("A") : 8'("a")) + 8'(n) - 8'd10;
    endfunction

    // body character: mostly printable, sometimes any byte, never a delimiter
    function logic [BYTE_W-1:0] body_char();
        logic [BYTE_W-1:0] c;
        c = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(8'h7e, 8'h20));
        while (c == SYM_DOLLAR || c == SYM_STAR)
        begin
            c = 8'($urandom_range(8'h7e, 8'h20));
        end
        return c;
    endfunction

    // checksum character that is not a hex digit and does not restart
    function logic [BYTE_W-1:0] junk_char();
        logic [BYTE_W-1:0] c;
        logic [HEX_W-1:0]  d;
        do
        begin
            c = 8'($urandom);
            d = sb.digit_of(c);
        end
        while (!d[4] || c == SYM_DOLLAR);
        return c;
    endfunction

    typedef enum int {FLAW_NONE, FLAW_WRONG_SUM, FLAW_NON_HEX, FLAW_TRUNCATED,
                      FLAW_RESTART} sentence_flaw_t;

    // one candidate sentence with random content and an optional flaw
    task send_sentence(input int body_len, input sentence_flaw_t flaw);
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] c;
        int                cut;
        bit                bad_pos;
        sum     = '0;
        cut     = (body_len > 0) ? $urandom_range(body_len - 1, 0) : 0;
        bad_pos = $urandom_range(1);
        send_byte(SYM_DOLLAR);
        for (int i = 0; i < body_len; i++)
        begin
            if (flaw == FLAW_TRUNCATED && i == cut)
            begin
                return;
            end
            if (flaw == FLAW_RESTART && i == cut)
            begin
                // a dollar mid sentence throws the partial checksum away
                send_byte(SYM_DOLLAR);
                sum = '0;
            end
            c = body_char();
            sum ^= c;
            send_byte(c);
        end
        send_byte(SYM_STAR);
        if (flaw == FLAW_WRONG_SUM)
        begin
            sum ^= 8'($urandom_range(255, 1));
        end
        if (flaw == FLAW_NON_HEX && !bad_pos)
            send_byte(junk_char());
        else
            send_byte(hex_char(sum[7:4], $urandom_range(1)));
        if (flaw == FLAW_NON_HEX && bad_pos)
            send_byte(junk_char());
        else
            send_byte(hex_char(sum[3:0], $urandom_range(1)));
    endtask

    // mostly well-formed sentences, lengths clustered around the limit when it is small
    task random_phase(input int n_items);
        int             first;
        int             r;
        int             len;
        int             edge_len;
        int             top_len;
        sentence_flaw_t flaw;
        first    = items_sent;
        // body length at which the first checksum character is the last byte allowed
        edge_len = int'(sb.limit) + int'(LIMIT_SLACK) - 3;
        top_len  = (edge_len + 6 < 262) ? edge_len + 6 : 262;
        while (items_sent - first < n_items)
        begin
            r = $urandom_range(99);
            if (r < 15)
            begin
                // noise between sentences, delimiters included
                repeat ($urandom_range(8, 1)) send_byte(8'($urandom));
            end
            else
            begin
                r = $urandom_range(99);
                if (r < 55)
                    len = $urandom_range(12, 0);
                else if (r < 85)
                    len = (edge_len <= 64) ? $urandom_range(edge_len + 2, edge_len - 2)
                                           : $urandom_range(40, 0);
                else if (r < 95)
                    len = $urandom_range(top_len, 0);
                else
                    len = $urandom_range(top_len, (top_len > 12) ? top_len - 12 : 0);
                r = $urandom_range(99);
                if (r < 70)
                    flaw = FLAW_NONE;
                else if (r < 78)
                    flaw = FLAW_WRONG_SUM;
                else if (r < 86)
                    flaw = FLAW_NON_HEX;
                else if (r < 93)
                    flaw = FLAW_TRUNCATED;
                else
                    flaw = FLAW_RESTART;
                send_sentence(len, flaw);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial
    begin
        sb         = new();
        idle_on    = 1'b1;
        items_sent = 0;
        rst_n               <= 1'b0;
        rx_ch.valid         <= 1'b0;
        rx_ch.rx_byte       <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.length_limit <= LIMIT_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at the reset limit
        send_byte(8'h00);          // extremes outside a sentence
        send_byte(8'hff);
        send_text("$*00");         // asterisk straight after the dollar
        send_text("$z*7a");        // lower-case hex digits
        send_text("$A*4g");        // non-hex checksum character
        send_text("$A$z*7A");      // dollar mid sentence, upper-case digits

        // smallest limit: overruns are frequent
        write_limit(8'd8);
        random_phase(175);
        wait_for_results();        // sender pauses until the pipeline is empty
        random_phase(175);

        // largest limit: nothing is dropped, byte count saturates
        write_limit(8'd255);
        random_phase(350);

        // a small limit with no gaps or stalls at all
        write_limit(8'd20);
        idle_on = 1'b0;
        random_phase(300);
        idle_on = 1'b1;

        // just below the top: limit plus slack lands exactly on the saturation value
        write_limit(8'd249);
        random_phase(300);

        write_limit(8'($urandom_range(255, 8)));
        random_phase(250);

        write_limit(LIMIT_RESET);
        random_phase(150);

        // drain and give stray results time to show up
        wait_for_results();
        repeat (6) @(posedge clk);

        if (sb.errors == 0 && sb.expected_results.size() == 0)
        begin
            $display("** nmea_sentence_framer_unit: PASSED **");
        end
        else
        begin
            $display("** nmea_sentence_framer_unit: FAILED **");
        end
        $finish;
    end

endmodule
